FILE: src/app_focus_tracker_with_id_map_macros.svh
// Assertion shorthands for the tracker controller.
// Each expects clk and rst_n in scope.
`ifndef APP_FOCUS_TRACKER_WITH_ID_MAP_MACROS_SVH
`define APP_FOCUS_TRACKER_WITH_ID_MAP_MACROS_SVH

// cond holds on every clock edge out of reset
`define AFT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons holds in the same cycle as ante
`define AFT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons holds in the cycle after ante
`define AFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/aft_pkg.sv
`timescale 1ns / 1ps

package aft_pkg;

    // input modes
    localparam logic [1:0] MODE_LAUNCH = 2'd0;
    localparam logic [1:0] MODE_FOCUS  = 2'd1;
    localparam logic [1:0] MODE_EXIT   = 2'd2;
    localparam logic [1:0] MODE_REPORT = 2'd3;

    // event kinds
    localparam logic [2:0] EV_LAUNCH  = 3'd0;
    localparam logic [2:0] EV_MAPPING = 3'd1;
    localparam logic [2:0] EV_BACKGND = 3'd2;
    localparam logic [2:0] EV_FOREGND = 3'd3;
    localparam logic [2:0] EV_EXIT    = 3'd4;
    localparam logic [2:0] EV_REPORT  = 3'd5;

    // largest five-digit title number
    localparam logic [16:0] NUM_MAX = 17'd99999;

    // prefix bit: 0 CUSA, 1 PPSA
    typedef struct packed {
        logic        prefix;
        logic [16:0] number;
    } title_t;

    typedef struct packed {
        logic [31:0] app;
        title_t      title;
    } map_entry_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] app;
        logic        title_valid;
        title_t      title;
    } event_t;

    // one event headed for the output register
    typedef struct packed {
        event_t ev;
        logic   last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACT,
        ST_EMIT
    } ctrl_state_t;

endpackage

FILE: src/aft_map_mem.sv
`timescale 1ns / 1ps

module aft_map_mem
    import aft_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  map_entry_t       wdata,
    input  logic [IDX_W-1:0] raddr,
    output map_entry_t       rdata
);

    map_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: src/aft_out_reg.sv
`timescale 1ns / 1ps

module aft_out_reg
    import aft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  out_item_t   push_item,
    output logic        push_ready,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [31:0] event_app,
    output logic        event_title_valid,
    output logic        event_prefix,
    output logic [16:0] event_number,
    output logic        last_event
);

    logic      valid_reg;
    out_item_t item_reg;

    assign push_ready = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push && push_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && push_ready)
        begin
            item_reg <= push_item;
        end
    end

    assign out_valid         = valid_reg;
    assign event_kind        = item_reg.ev.kind;
    assign event_app         = item_reg.ev.app;
    assign event_title_valid = item_reg.ev.title_valid;
    assign event_prefix      = item_reg.ev.title.prefix;
    assign event_number      = item_reg.ev.title.number;
    assign last_event        = item_reg.last;

endmodule

FILE: src/aft_ctrl.sv
`timescale 1ns / 1ps
`include "app_focus_tracker_with_id_map_macros.svh"

module aft_ctrl
    import aft_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5,
    parameter int CNT_W = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       mode,
    input  logic [31:0]      old_app,
    input  logic [31:0]      app_ident,
    input  logic             title_prefix,
    input  logic [16:0]      title_number,
    output logic             push,
    output out_item_t        push_item,
    input  logic             push_ready,
    output logic             mem_we,
    output logic [IDX_W-1:0] mem_waddr,
    output map_entry_t       mem_wdata,
    output logic [IDX_W-1:0] mem_raddr,
    input  map_entry_t       mem_rdata
);

    localparam logic [CNT_W-1:0] FULL     = CNT_W'(DEPTH);
    localparam logic [CNT_W:0]   DEPTH_W  = (CNT_W+1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    ctrl_state_t state_reg, state_next;

    // item under work
    logic [1:0]  mode_reg, mode_next;
    logic [31:0] old_app_reg, old_app_next;
    logic [31:0] app_reg, app_next;
    title_t      title_reg, title_next;

    // scan
    logic [CNT_W-1:0] scan_i_reg, scan_i_next;
    logic             rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0] rd_slot_reg, rd_slot_next;
    logic             os_found_reg, os_found_next;
    title_t           os_title_reg, os_title_next;
    logic             ns_found_reg, ns_found_next;
    logic [IDX_W-1:0] ns_slot_reg, ns_slot_next;
    title_t           ns_title_reg, ns_title_next;

    // ring bookkeeping
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] oldest_reg, oldest_next;

    // pending launch and foreground
    logic        pend_valid_reg, pend_valid_next;
    title_t      pend_title_reg, pend_title_next;
    logic [31:0] fg_app_reg, fg_app_next;
    logic        fg_tv_reg, fg_tv_next;
    title_t      fg_title_reg, fg_title_next;

    // queued events of this item
    event_t     evt_reg [0:2];
    event_t     evt_next [0:2];
    logic [1:0] evt_n_reg, evt_n_next;
    logic [1:0] emit_idx_reg, emit_idx_next;

    logic [CNT_W:0]   rd_sum;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W:0]   ins_sum;
    logic [IDX_W-1:0] ins_slot;
    logic [IDX_W-1:0] oldest_inc;
    logic             full;
    logic             title_ok;

    // ring slot of scan step i and of the next free slot
    assign rd_sum     = (CNT_W+1)'(oldest_reg) + (CNT_W+1)'(scan_i_reg);
    assign rd_addr    = (rd_sum >= DEPTH_W) ? IDX_W'(rd_sum - DEPTH_W) : IDX_W'(rd_sum);
    assign ins_sum    = (CNT_W+1)'(oldest_reg) + (CNT_W+1)'(count_reg);
    assign full       = (count_reg == FULL);
    assign ins_slot   = full ? oldest_reg :
                        ((ins_sum >= DEPTH_W) ? IDX_W'(ins_sum - DEPTH_W) : IDX_W'(ins_sum));
    assign oldest_inc = (oldest_reg == LAST_IDX) ? '0 : oldest_reg + 1'b1;
    assign title_ok   = (title_reg.number <= NUM_MAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_valid_reg   <= 1'b0;
            count_reg      <= '0;
            oldest_reg     <= '0;
            pend_valid_reg <= 1'b0;
            pend_title_reg <= '0;
            fg_app_reg     <= '0;
            fg_tv_reg      <= 1'b0;
            fg_title_reg   <= '0;
            evt_n_reg      <= '0;
            emit_idx_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_valid_reg   <= rd_valid_next;
            count_reg      <= count_next;
            oldest_reg     <= oldest_next;
            pend_valid_reg <= pend_valid_next;
            pend_title_reg <= pend_title_next;
            fg_app_reg     <= fg_app_next;
            fg_tv_reg      <= fg_tv_next;
            fg_title_reg   <= fg_title_next;
            evt_n_reg      <= evt_n_next;
            emit_idx_reg   <= emit_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        old_app_reg  <= old_app_next;
        app_reg      <= app_next;
        title_reg    <= title_next;
        scan_i_reg   <= scan_i_next;
        rd_slot_reg  <= rd_slot_next;
        os_found_reg <= os_found_next;
        os_title_reg <= os_title_next;
        ns_found_reg <= ns_found_next;
        ns_slot_reg  <= ns_slot_next;
        ns_title_reg <= ns_title_next;
        evt_reg      <= evt_next;
    end

    always_comb
    begin
        logic [1:0]  n;
        logic        do_ins;
        title_t      ins_title;
        logic        ns_ok;
        title_t      nt;
        logic [31:0] fg_mid;

        n         = '0;
        do_ins    = 1'b0;
        ins_title = title_reg;
        ns_ok     = 1'b0;
        nt        = ns_title_reg;
        fg_mid    = fg_app_reg;

        state_next      = state_reg;
        mode_next       = mode_reg;
        old_app_next    = old_app_reg;
        app_next        = app_reg;
        title_next      = title_reg;
        scan_i_next     = scan_i_reg;
        rd_valid_next   = 1'b0;
        rd_slot_next    = rd_slot_reg;
        os_found_next   = os_found_reg;
        os_title_next   = os_title_reg;
        ns_found_next   = ns_found_reg;
        ns_slot_next    = ns_slot_reg;
        ns_title_next   = ns_title_reg;
        count_next      = count_reg;
        oldest_next     = oldest_reg;
        pend_valid_next = pend_valid_reg;
        pend_title_next = pend_title_reg;
        fg_app_next     = fg_app_reg;
        fg_tv_next      = fg_tv_reg;
        fg_title_next   = fg_title_reg;
        evt_next        = evt_reg;
        evt_n_next      = evt_n_reg;
        emit_idx_next   = emit_idx_reg;

        in_stall  = (state_reg != ST_IDLE);
        push      = 1'b0;
        push_item = '{ev: evt_reg[emit_idx_reg], last: (emit_idx_reg == evt_n_reg - 2'd1)};
        mem_we    = 1'b0;
        mem_waddr = ns_slot_reg;
        mem_wdata = '{app: app_reg, title: title_reg};
        mem_raddr = rd_addr;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next     = mode;
                    old_app_next  = old_app;
                    app_next      = app_ident;
                    title_next    = '{prefix: title_prefix, number: title_number};
                    scan_i_next   = '0;
                    os_found_next = 1'b0;
                    ns_found_next = 1'b0;
                    // only focus and exit need the table
                    if (mode == MODE_FOCUS || mode == MODE_EXIT)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_ACT;
                    end
                end
            end

            ST_SCAN:
            begin
                if (rd_valid_reg)
                begin
                    if (old_app_reg != '0 && mem_rdata.app == old_app_reg)
                    begin
                        os_found_next = 1'b1;
                        os_title_next = mem_rdata.title;
                    end
                    if (app_reg != '0 && mem_rdata.app == app_reg)
                    begin
                        ns_found_next = 1'b1;
                        ns_slot_next  = rd_slot_reg;
                        ns_title_next = mem_rdata.title;
                    end
                end
                if (scan_i_reg != count_reg)
                begin
                    rd_valid_next = 1'b1;
                    rd_slot_next  = rd_addr;
                    scan_i_next   = scan_i_reg + 1'b1;
                end
                else if (!rd_valid_reg)
                begin
                    state_next = ST_ACT;
                end
            end

            ST_ACT:
            begin
                case (mode_reg)
                    MODE_LAUNCH:
                    begin
                        if (title_ok)
                        begin
                            pend_valid_next = 1'b1;
                            pend_title_next = title_reg;
                            evt_next[n] = '{kind: EV_LAUNCH, app: '0, title_valid: 1'b1,
                                            title: title_reg};
                            n = n + 2'd1;
                        end
                    end

                    MODE_FOCUS:
                    begin
                        ns_ok = ns_found_reg;
                        if (pend_valid_reg)
                        begin
                            if (!ns_found_reg && app_reg != '0)
                            begin
                                do_ins    = 1'b1;
                                ins_title = pend_title_reg;
                                ns_ok     = 1'b1;
                                nt        = pend_title_reg;
                                evt_next[n] = '{kind: EV_MAPPING, app: app_reg,
                                                title_valid: 1'b1, title: pend_title_reg};
                                n = n + 2'd1;
                            end
                            pend_valid_next = 1'b0;
                            pend_title_next = '0;
                        end
                        if (os_found_reg && old_app_reg != app_reg && fg_app_reg == old_app_reg)
                        begin
                            evt_next[n] = '{kind: EV_BACKGND, app: old_app_reg,
                                            title_valid: 1'b1, title: os_title_reg};
                            n = n + 2'd1;
                            fg_mid        = '0;
                            fg_app_next   = '0;
                            fg_tv_next    = 1'b0;
                            fg_title_next = '0;
                        end
                        if (ns_ok && old_app_reg != app_reg && fg_mid != app_reg)
                        begin
                            evt_next[n] = '{kind: EV_FOREGND, app: app_reg,
                                            title_valid: 1'b1, title: nt};
                            n = n + 2'd1;
                            fg_app_next   = app_reg;
                            fg_tv_next    = 1'b1;
                            fg_title_next = nt;
                        end
                    end

                    MODE_EXIT:
                    begin
                        if (title_ok)
                        begin
                            if (app_reg != '0)
                            begin
                                if (ns_found_reg)
                                begin
                                    // known app: rewrite the title in place if it moved
                                    if (ns_title_reg != title_reg)
                                    begin
                                        mem_we = 1'b1;
                                        evt_next[n] = '{kind: EV_MAPPING, app: app_reg,
                                                        title_valid: 1'b1, title: title_reg};
                                        n = n + 2'd1;
                                    end
                                end
                                else
                                begin
                                    do_ins = 1'b1;
                                    evt_next[n] = '{kind: EV_MAPPING, app: app_reg,
                                                    title_valid: 1'b1, title: title_reg};
                                    n = n + 2'd1;
                                end
                            end
                            evt_next[n] = '{kind: EV_EXIT, app: app_reg, title_valid: 1'b1,
                                            title: title_reg};
                            n = n + 2'd1;
                            if (fg_app_reg == app_reg)
                            begin
                                fg_app_next   = '0;
                                fg_tv_next    = 1'b0;
                                fg_title_next = '0;
                            end
                        end
                    end

                    MODE_REPORT:
                    begin
                        evt_next[n] = '{kind: EV_REPORT, app: fg_app_reg,
                                        title_valid: fg_tv_reg, title: fg_title_reg};
                        n = n + 2'd1;
                    end

                    default:
                    begin
                    end
                endcase

                // append at the ring tail, or overwrite the oldest when full
                if (do_ins)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ins_slot;
                    mem_wdata = '{app: app_reg, title: ins_title};
                    if (full)
                    begin
                        oldest_next = oldest_inc;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end

                evt_n_next    = n;
                emit_idx_next = '0;
                state_next    = (n == '0) ? ST_IDLE : ST_EMIT;
            end

            ST_EMIT:
            begin
                push = 1'b1;
                if (push_ready)
                begin
                    if (emit_idx_reg == evt_n_reg - 2'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + 2'd1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `AFT_ASSERT_ALWAYS(a_count_max, count_reg <= FULL, "map count above table depth")
    `AFT_ASSERT_SAME(a_write_in_act, mem_we, state_reg == ST_ACT, "table write outside act")
    `AFT_ASSERT_NEXT(a_full_stays, (state_reg == ST_ACT && full), count_reg == FULL, "full table shrank")
    `AFT_ASSERT_NEXT(a_focus_clears_pend, (state_reg == ST_ACT && mode_reg == MODE_FOCUS), !pend_valid_reg, "pending title survived focus change")
    `AFT_ASSERT_ALWAYS(a_fg_consistent, fg_tv_reg || fg_app_reg == '0, "foreground app without title")

endmodule

FILE: src/app_focus_tracker_with_id_map.sv
`timescale 1ns / 1ps

// App focus tracker with an app-id to title-id map. Takes one input transfer at a
// time: launch, focus change, exit or report. A title id is a prefix bit (0 CUSA,
// 1 PPSA) and five decimal digits; numbers above 99999 make launch and exit do
// nothing. The map holds up to TABLE_DEPTH nonzero app ids in a ring and drops the
// oldest entry when full. Each input yields zero to three event transfers, the last
// flagged by last_event. Focus change and exit run a linear search of the map
// memory, one entry read per cycle; launch and report skip the search. The map
// comes out of reset empty and needs no clearing pass. in_stall is high from the
// transfer of an item until its last event has gone into the output register,
// which holds one event while the tracker moves on.
module app_focus_tracker_with_id_map
    import aft_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [31:0] old_app,
    input  logic [31:0] app_ident,
    input  logic        title_prefix,
    input  logic [16:0] title_number,
    // event channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [31:0] event_app,
    output logic        event_title_valid,
    output logic        event_prefix,
    output logic [16:0] event_number,
    output logic        last_event
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic             push;
    out_item_t        push_item;
    logic             push_ready;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    map_entry_t       mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    map_entry_t       mem_rdata;

    // sequencer: search, update, event list
    aft_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .old_app      (old_app),
        .app_ident    (app_ident),
        .title_prefix (title_prefix),
        .title_number (title_number),
        .push         (push),
        .push_item    (push_item),
        .push_ready   (push_ready),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    // app/title map, one write and one registered read per cycle
    aft_map_mem #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_map_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register
    aft_out_reg u_out_reg (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .push_item         (push_item),
        .push_ready        (push_ready),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .event_kind        (event_kind),
        .event_app         (event_app),
        .event_title_valid (event_title_valid),
        .event_prefix      (event_prefix),
        .event_number      (event_number),
        .last_event        (last_event)
    );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import aft_pkg::*;

    localparam int DEPTH       = 32;
    localparam int RAND_ITEMS  = 125;
    localparam int ID_POOL     = 36;    // a little larger than the map, so it fills and evicts
    localparam int PAUSE_EVERY = 55;
    // Longest quiet stretch of a correct run: a sender gap, a full-table search with
    // events and a receiver stall. The limit is taken far above that.
    localparam int IDLE_LIMIT  = 3000;
    localparam int TAIL_CYCLES = 100;
    localparam int MAX_PRINT   = 40;

    // one row of stimulus; fixed rows carry a hand-written expectation
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] old_id;
        logic [31:0] new_id;
        logic        pfx;
        logic [16:0] num;
        logic        fixed;
        logic        fixed_has;
        out_item_t   fixed_ev;
    } stim_row_t;

    bit          clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  mode = MODE_LAUNCH;
    logic [31:0] old_app = '0;
    logic [31:0] app_ident = '0;
    logic        title_prefix = 1'b0;
    logic [16:0] title_number = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  event_kind;
    logic [31:0] event_app;
    logic        event_title_valid;
    logic        event_prefix;
    logic [16:0] event_number;
    logic        last_event;

    // travels with the payload so the monitor knows how to build the expectation
    logic        row_fixed = 1'b0;
    logic        row_fixed_has = 1'b0;
    out_item_t   row_fixed_ev = '0;

    // tracker shadow state
    logic [31:0] tbl_app [DEPTH];
    title_t      tbl_title [DEPTH];
    int          tbl_count = 0;
    int          tbl_oldest = 0;
    logic        pend_v = 1'b0;
    title_t      pend_t = '0;
    logic [31:0] fg_id = '0;
    logic        fg_tv = 1'b0;
    title_t      fg_t = '0;

    out_item_t   step_q [$];    // events of the transfer being predicted
    out_item_t   event_q [$];   // events still owed by the block

    // shadow state published to the sender, one transfer behind
    logic [31:0] hint_oldest_id = '0;
    logic [31:0] hint_fg_id = '0;

    logic [31:0] id_pool [ID_POOL];
    int          errors = 0;
    int          items_sent = 0;
    int          tx_calm = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    app_focus_tracker_with_id_map #(
        .TABLE_DEPTH (DEPTH)
    ) i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .mode              (mode),
        .old_app           (old_app),
        .app_ident         (app_ident),
        .title_prefix      (title_prefix),
        .title_number      (title_number),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .event_kind        (event_kind),
        .event_app         (event_app),
        .event_title_valid (event_title_valid),
        .event_prefix      (event_prefix),
        .event_number      (event_number),
        .last_event        (last_event)
    );

    // ------------------------------------------------------------------
    // Checking helpers
    // ------------------------------------------------------------------
    task automatic flag(input string msg);
        errors++;
        if (errors <= MAX_PRINT)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Shadow tracker
    // ------------------------------------------------------------------

    // slot holding id among the live ring entries, -1 when absent; zero never matches
    function automatic int find_entry(input logic [31:0] id);
        int i;
        int s;
        find_entry = -1;
        if (id != '0)
            for (i = 0; i < tbl_count; i++)
            begin
                s = (tbl_oldest + i) % DEPTH;
                if (find_entry < 0 && tbl_app[s] == id)
                    find_entry = s;
            end
    endfunction

    task automatic post_event(input logic [2:0] kind, input logic [31:0] id,
                              input logic tv, input title_t t);
        out_item_t e;
        e = '0;
        e.ev.kind = kind;
        e.ev.app = id;
        e.ev.title_valid = tv;
        if (tv)
            e.ev.title = t;
        step_q.push_back(e);
    endtask

    // bind id to t; a mapping event only when the map actually changes
    task automatic bind_title(input logic [31:0] id, input title_t t);
        int s;
        int slot;
        s = find_entry(id);
        if (id == '0)
            s = -2;
        if (s >= 0)
        begin
            if (tbl_title[s] != t)
            begin
                tbl_title[s] = t;
                post_event(EV_MAPPING, id, 1'b1, t);
            end
        end
        else if (s == -1)
        begin
            if (tbl_count >= DEPTH)
            begin
                // full: overwrite the oldest entry
                slot = tbl_oldest;
                tbl_oldest = (tbl_oldest + 1) % DEPTH;
            end
            else
            begin
                slot = (tbl_oldest + tbl_count) % DEPTH;
                tbl_count++;
            end
            tbl_app[slot] = id;
            tbl_title[slot] = t;
            post_event(EV_MAPPING, id, 1'b1, t);
        end
    endtask

    // one accepted transfer: update shadow state, leave its events in step_q
    task automatic advance_tracker(input logic [1:0] m, input logic [31:0] old_id,
                                   input logic [31:0] id, input logic pfx,
                                   input logic [16:0] num);
        title_t    t;
        title_t    old_t;
        title_t    none;
        int        os;
        int        ns;
        out_item_t e;
        t.prefix = pfx;
        t.number = num;
        none = '0;
        step_q.delete();
        case (m)
            MODE_LAUNCH:
            begin
                // out-of-range digits are not a title: ignored
                if (num <= NUM_MAX)
                begin
                    pend_v = 1'b1;
                    pend_t = t;
                    post_event(EV_LAUNCH, '0, 1'b1, t);
                end
            end
            MODE_FOCUS:
            begin
                // old title is read before any eviction below
                os = find_entry(old_id);
                old_t = (os >= 0) ? tbl_title[os] : none;
                if (pend_v)
                begin
                    if (find_entry(id) < 0)
                        bind_title(id, pend_t);
                    pend_v = 1'b0;
                    pend_t = '0;
                end
                ns = find_entry(id);
                if (os >= 0 && old_id != id && fg_id == old_id)
                begin
                    post_event(EV_BACKGND, old_id, 1'b1, old_t);
                    fg_id = '0;
                    fg_tv = 1'b0;
                    fg_t = '0;
                end
                if (ns >= 0 && old_id != id && fg_id != id)
                begin
                    post_event(EV_FOREGND, id, 1'b1, tbl_title[ns]);
                    fg_id = id;
                    fg_tv = 1'b1;
                    fg_t = tbl_title[ns];
                end
            end
            MODE_EXIT:
            begin
                if (num <= NUM_MAX)
                begin
                    bind_title(id, t);
                    post_event(EV_EXIT, id, 1'b1, t);
                    if (fg_id == id)
                    begin
                        fg_id = '0;
                        fg_tv = 1'b0;
                        fg_t = '0;
                    end
                end
            end
            default:
                post_event(EV_REPORT, fg_id, fg_tv, fg_t);
        endcase
        if (step_q.size() > 0)
        begin
            e = step_q[step_q.size() - 1];
            e.last = 1'b1;
            step_q[step_q.size() - 1] = e;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: both channels sampled at the rising edge, before the
    // block's own updates land, so the order of processes does not matter.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t want;
        int        k;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (event_q.size() == 0)
                    flag("event transfer with nothing expected");
                else
                begin
                    want = event_q.pop_front();
                    check_field("event_kind", 32'(event_kind), 32'(want.ev.kind));
                    check_field("event_app", event_app, want.ev.app);
                    check_field("event_title_valid", 32'(event_title_valid),
                                32'(want.ev.title_valid));
                    check_field("event_prefix", 32'(event_prefix),
                                32'(want.ev.title.prefix));
                    check_field("event_number", 32'(event_number),
                                32'(want.ev.title.number));
                    check_field("last_event", 32'(last_event), 32'(want.last));
                end
            end
            if (in_valid && !in_stall)
            begin
                // shadow state always advances; fixed rows override the events
                advance_tracker(mode, old_app, app_ident, title_prefix, title_number);
                if (row_fixed)
                begin
                    if (row_fixed_has)
                        event_q.push_back(row_fixed_ev);
                end
                else
                    for (k = 0; k < step_q.size(); k++)
                        event_q.push_back(step_q[k]);
                hint_oldest_id <= (tbl_count != 0) ? tbl_app[tbl_oldest] : '0;
                hint_fg_id <= fg_id;
            end
        end
    end

    // ------------------------------------------------------------------
    // Pacing: a random wait per transfer, with runs of back-to-back ones
    // ------------------------------------------------------------------
    task automatic draw_wait(inout int calm_left, output int n);
        if (calm_left > 0)
        begin
            calm_left--;
            n = 0;
        end
        else
        begin
            if ($urandom_range(0, 11) == 0)
                calm_left = $urandom_range(10, 25);
            n = $urandom_range(0, 14);
        end
    endtask

    // event side: stall a random number of cycles before each transfer
    initial
    begin
        int n;
        int calm;
        calm = 0;
        wait (rst_n);
        forever
        begin
            draw_wait(calm, n);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    function automatic stim_row_t mk_row(input logic [1:0] m, input logic [31:0] o,
                                         input logic [31:0] a, input logic p,
                                         input logic [16:0] n);
        mk_row = '0;
        mk_row.mode = m;
        mk_row.old_id = o;
        mk_row.new_id = a;
        mk_row.pfx = p;
        mk_row.num = n;
    endfunction

    // row with one hand-written event (or none when has is low)
    function automatic stim_row_t mk_fixed(input logic [1:0] m, input logic [31:0] o,
                                           input logic [31:0] a, input logic p,
                                           input logic [16:0] n, input logic has,
                                           input logic [2:0] kind,
                                           input logic [31:0] e_app, input logic e_tv,
                                           input logic e_pfx, input logic [16:0] e_num);
        mk_fixed = mk_row(m, o, a, p, n);
        mk_fixed.fixed = 1'b1;
        mk_fixed.fixed_has = has;
        mk_fixed.fixed_ev.ev.kind = kind;
        mk_fixed.fixed_ev.ev.app = e_app;
        mk_fixed.fixed_ev.ev.title_valid = e_tv;
        mk_fixed.fixed_ev.ev.title.prefix = e_pfx;
        mk_fixed.fixed_ev.ev.title.number = e_num;
        mk_fixed.fixed_ev.last = 1'b1;
    endfunction

    task automatic send_item(input stim_row_t r);
        int gap;
        draw_wait(tx_calm, gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        mode          <= r.mode;
        old_app       <= r.old_id;
        app_ident     <= r.new_id;
        title_prefix  <= r.pfx;
        title_number  <= r.num;
        row_fixed     <= r.fixed;
        row_fixed_has <= r.fixed_has;
        row_fixed_ev  <= r.fixed_ev;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // launch and exit with bad digits are ignored by the block
        if (!((r.mode == MODE_LAUNCH || r.mode == MODE_EXIT) && r.num > NUM_MAX))
            items_sent++;
    endtask

    // hold off input until every owed event has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (event_q.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_id();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            rand_id = '0;
        else if (r == 1)
            rand_id = $urandom;
        else
            rand_id = id_pool[$urandom_range(0, ID_POOL - 1)];
    endfunction

    function automatic logic [16:0] ok_num();
        ok_num = 17'($urandom_range(0, NUM_MAX));
    endfunction

    function automatic logic [16:0] bad_num();
        bad_num = 17'($urandom_range(NUM_MAX + 1, 17'h1FFFF));
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        stim_row_t   script [$];
        int          k;
        int          goal;
        int          next_pause;
        logic [31:0] a;
        logic [16:0] nb;
        logic        pb;

        for (k = 0; k < ID_POOL; k++)
        begin
            id_pool[k] = $urandom;
            if (id_pool[k] == '0)
                id_pool[k] = 32'd1;
        end

        // directed part
        // fresh block reports an empty foreground
        script.push_back(mk_fixed(MODE_REPORT, '0, '0, 1'b0, '0,
                                  1'b1, EV_REPORT, '0, 1'b0, 1'b0, '0));
        // digits above 99999: launch and exit do nothing
        script.push_back(mk_fixed(MODE_LAUNCH, 32'hFFFF_FFFF, '0, 1'b1, 17'd100000,
                                  1'b0, EV_LAUNCH, '0, 1'b0, 1'b0, '0));
        script.push_back(mk_fixed(MODE_EXIT, '0, 32'hFFFF_FFFF, 1'b1, 17'h1FFFF,
                                  1'b0, EV_EXIT, '0, 1'b0, 1'b0, '0));
        // lowest title, then a second launch replaces the pending one
        script.push_back(mk_fixed(MODE_LAUNCH, '0, '0, 1'b0, 17'd0,
                                  1'b1, EV_LAUNCH, '0, 1'b1, 1'b0, 17'd0));
        script.push_back(mk_fixed(MODE_LAUNCH, '0, '0, 1'b1, NUM_MAX,
                                  1'b1, EV_LAUNCH, '0, 1'b1, 1'b1, NUM_MAX));
        // bind pending title to the all-ones app and bring it to front
        script.push_back(mk_row(MODE_FOCUS, '0, 32'hFFFF_FFFF, 1'b0, '0));
        script.push_back(mk_row(MODE_REPORT, '0, '0, 1'b0, '0));
        // same app on both sides: nothing
        script.push_back(mk_row(MODE_FOCUS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0));
        // same app with a pending title: binding still happens, no focus events
        script.push_back(mk_fixed(MODE_LAUNCH, '0, '0, 1'b0, 17'd12345,
                                  1'b1, EV_LAUNCH, '0, 1'b1, 1'b0, 17'd12345));
        script.push_back(mk_row(MODE_FOCUS, 32'd1, 32'd1, 1'b0, '0));
        // background then foreground
        script.push_back(mk_row(MODE_FOCUS, 32'hFFFF_FFFF, 32'd1, 1'b0, '0));
        script.push_back(mk_row(MODE_REPORT, '0, '0, 1'b0, '0));
        // exit with the same title (no mapping), then with a new one
        script.push_back(mk_row(MODE_EXIT, '0, 32'd1, 1'b0, 17'd12345));
        script.push_back(mk_row(MODE_EXIT, '0, 32'd1, 1'b1, 17'd54321));
        // zero app never enters the map
        script.push_back(mk_fixed(MODE_EXIT, '0, '0, 1'b1, 17'd77,
                                  1'b1, EV_EXIT, '0, 1'b1, 1'b1, 17'd77));
        script.push_back(mk_fixed(MODE_LAUNCH, '0, '0, 1'b1, 17'd1,
                                  1'b1, EV_LAUNCH, '0, 1'b1, 1'b1, 17'd1));
        script.push_back(mk_row(MODE_FOCUS, 32'd1, '0, 1'b0, '0));
        script.push_back(mk_row(MODE_REPORT, '0, '0, 1'b0, '0));
        script.push_back(mk_row(MODE_FOCUS, '0, 32'd1, 1'b0, '0));
        // prefix change alone counts as a different title
        script.push_back(mk_row(MODE_EXIT, '0, 32'hFFFF_FFFF, 1'b0, NUM_MAX));
        // losing focus to an unmapped app: background only
        script.push_back(mk_row(MODE_FOCUS, 32'd1, 32'h8000_0000, 1'b0, '0));
        script.push_back(mk_row(MODE_REPORT, '0, '0, 1'b0, '0));
        script.push_back(mk_row(MODE_EXIT, '0, 32'h8000_0000, 1'b0, 17'h10000));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < script.size(); k++)
            send_item(script[k]);
        wait_drained();

        // random part: mostly launch/focus/exit flows with random content
        goal = items_sent + RAND_ITEMS;
        next_pause = items_sent + PAUSE_EVERY;
        while (items_sent < goal)
        begin
            if (items_sent >= next_pause)
            begin
                wait_drained();
                next_pause = items_sent + PAUSE_EVERY;
            end
            pb = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    // launch, then switch focus, often away from the current front
                    send_item(mk_row(MODE_LAUNCH, $urandom, $urandom, pb, ok_num()));
                    send_item(mk_row(MODE_FOCUS,
                                     $urandom_range(0, 1) ? hint_fg_id : rand_id(),
                                     rand_id(), 1'($urandom_range(0, 1)),
                                     17'($urandom)));
                end
                3:
                begin
                    // bring the oldest entry to front, then bind a fresh app: on a
                    // full map this evicts the entry that is losing focus
                    send_item(mk_row(MODE_REPORT, $urandom, $urandom, pb, 17'($urandom)));
                    send_item(mk_row(MODE_FOCUS, hint_fg_id, hint_oldest_id, pb, '0));
                    send_item(mk_row(MODE_LAUNCH, '0, '0, pb, ok_num()));
                    send_item(mk_row(MODE_FOCUS, hint_oldest_id, $urandom, pb, '0));
                end
                4, 5:
                begin
                    // exit, sometimes repeated with the same or a new title
                    a = rand_id();
                    nb = ok_num();
                    send_item(mk_row(MODE_EXIT, $urandom, a, pb, nb));
                    if ($urandom_range(0, 1))
                    begin
                        if ($urandom_range(0, 1))
                        begin
                            pb = 1'($urandom_range(0, 1));
                            nb = ok_num();
                        end
                        send_item(mk_row(MODE_EXIT, $urandom, a, pb, nb));
                    end
                end
                6:
                begin
                    send_item(mk_row(MODE_REPORT, $urandom, $urandom, pb, 17'($urandom)));
                    if ($urandom_range(0, 1))
                        send_item(mk_row(MODE_FOCUS, hint_fg_id, rand_id(), pb, '0));
                end
                7:
                begin
                    // same app on both sides with a pending title
                    a = rand_id();
                    send_item(mk_row(MODE_LAUNCH, '0, '0, pb, ok_num()));
                    send_item(mk_row(MODE_FOCUS, a, a, pb, '0));
                end
                8:
                    // noise across every field
                    send_item(mk_row(2'($urandom_range(0, 3)), $urandom, $urandom, pb,
                                     17'($urandom_range(0, 17'h1FFFF))));
                default:
                begin
                    // broken flows: bad digits, focus without a launch
                    case ($urandom_range(0, 2))
                        0: send_item(mk_row(MODE_LAUNCH, $urandom, $urandom, pb,
                                            bad_num()));
                        1: send_item(mk_row(MODE_EXIT, $urandom, rand_id(), pb,
                                            bad_num()));
                        default: send_item(mk_row(MODE_FOCUS, rand_id(), rand_id(),
                                                  pb, 17'($urandom)));
                    endcase
                end
            endcase
        end

        wait_drained();
        // let any stray event surface before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run after too many cycles with no transfer at all
    // ------------------------------------------------------------------
    initial
    begin
        int idle;
        idle = 0;
        wait (rst_n);
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("status: fail");
        $finish;
    end

endmodule
